/* rtl/tsf_pkg.sv */
// Shared types, constants and register indexes of the touch sample filter.
// Used by every module of the block; depends on nothing.
package tsf_pkg;

	localparam int SAMPLES_PER_AXIS = 5;
	localparam int DROP_EACH_END = 1;
	localparam int KEPT = SAMPLES_PER_AXIS - 2 * DROP_EACH_END;
	localparam int IDX_W = $clog2(SAMPLES_PER_AXIS);
	localparam int SMP_W = 12;
	localparam int SUM_W = 16;
	localparam int RECIP_W = 33;
	localparam int COORD_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int PROD_W = 46;

	localparam longint unsigned RECIP_L =
		(KEPT > 0) ? ((64'd1 << 32) + 64'(KEPT) - 64'd1) / 64'(KEPT) : 64'd0;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

	localparam logic [COORD_W-1:0] COORD_IDLE = 16'hFFFF;
	localparam logic [SMP_W-1:0] AGREE_LIM_RST = 12'd50;

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_PEN_UP = 2'd1;
	localparam logic [1:0] KIND_ACK = 2'd2;

	localparam logic [1:0] GRP_FIRST_A = 2'd0;
	localparam logic [1:0] GRP_SECOND_A = 2'd1;
	localparam logic [1:0] GRP_FIRST_B = 2'd2;
	localparam logic [1:0] GRP_SECOND_B = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWAP_AXES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AGREE_LIM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_X_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 3'd6;

	typedef struct packed {
		logic [1:0] kind;
		logic [SMP_W-1:0] sample;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic pressed;
		logic new_press;
		logic reading_valid;
	} result_t;

	typedef enum logic [1:0] {
		OP_STORE,
		OP_GROUP_END,
		OP_PEN_UP,
		OP_ACK
	} op_e;

	typedef struct packed {
		op_e op;
		logic [IDX_W-1:0] idx;
		logic [1:0] grp;
		logic [SMP_W-1:0] sample;
	} op_t;

	typedef struct packed {
		logic output_mode;
		logic swap_axes;
		logic [SMP_W-1:0] agree_lim;
		logic signed [31:0] x_gain;
		logic signed [31:0] x_offset;
		logic signed [31:0] y_gain;
		logic signed [31:0] y_offset;
	} cfg_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_sts_t;

endpackage

/* rtl/tsf_front.sv */
// Front end: accepts input transactions, tracks sample and group position,
// and turns each sample, pen-up or acknowledge transaction into an operation for the queue. Uses tsf_pkg.
module tsf_front (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input tsf_pkg::item_t item,
	input tsf_pkg::q_sts_t q_sts,
	output logic q_push,
	output tsf_pkg::op_t q_wdata
);
	import tsf_pkg::*;

	logic [IDX_W-1:0] cnt_q;
	logic [1:0] grp_q;
	logic take;
	logic last;

	assign item_ready = !q_sts.full;
	assign take = item_valid && item_ready;
	assign last = (cnt_q == IDX_W'(SAMPLES_PER_AXIS - 1));

	always_comb begin
		q_push = 1'b0;
		q_wdata.op = OP_STORE;
		q_wdata.idx = cnt_q;
		q_wdata.grp = grp_q;
		q_wdata.sample = item.sample;
		case (item.kind)
			KIND_SAMPLE: begin
				q_push = take;
				q_wdata.op = last ? OP_GROUP_END : OP_STORE;
			end
			KIND_PEN_UP: begin
				q_push = take;
				q_wdata.op = OP_PEN_UP;
			end
			KIND_ACK: begin
				q_push = take;
				q_wdata.op = OP_ACK;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			grp_q <= '0;
		end else if (take) begin
			if (item.kind == KIND_SAMPLE) begin
				if (last) begin
					cnt_q <= '0;
					grp_q <= grp_q + 2'd1;
				end else begin
					cnt_q <= cnt_q + IDX_W'(1);
				end
			end else if (item.kind == KIND_PEN_UP) begin
				cnt_q <= '0;
				grp_q <= '0;
			end
		end
	end

endmodule

/* rtl/tsf_queue.sv */
// Two-entry queue of operations between the front end and the back end.
// Uses tsf_pkg for the operation type and the control structs.
module tsf_queue (
	input logic clk,
	input logic arst_n,
	input tsf_pkg::q_ctl_t q_ctl,
	input tsf_pkg::op_t wdata,
	output tsf_pkg::op_t rdata,
	output tsf_pkg::q_sts_t q_sts
);
	import tsf_pkg::*;

	op_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] fill_q;

	assign q_sts.full = (fill_q == 2'd2);
	assign q_sts.empty = (fill_q == 2'd0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (q_ctl.push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (q_ctl.push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_ctl.pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (q_ctl.push && !q_ctl.pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (q_ctl.pop && !q_ctl.push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

/* rtl/tsf_back.sv */
// Back end: stores samples, sorts each group, takes the trimmed mean, checks the
// reading and, unless output_mode selects raw, scales it; tracks the press state and
// holds the result. Uses tsf_pkg.
module tsf_back (
	input logic clk,
	input logic arst_n,
	input tsf_pkg::cfg_t cfg,
	input tsf_pkg::op_t q_rdata,
	input logic q_empty,
	output logic q_pop,
	output logic result_valid,
	input logic result_ready,
	output tsf_pkg::result_t result
);
	import tsf_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SORT = 6'b000010,
		ST_MEAN = 6'b000100,
		ST_STORE = 6'b001000,
		ST_CHECK = 6'b010000,
		ST_SCALE = 6'b100000
	} st_t;

	st_t state_q;
	logic [SMP_W-1:0] grp_q [SAMPLES_PER_AXIS];
	logic [SMP_W-1:0] sorted [SAMPLES_PER_AXIS];
	logic [IDX_W-1:0] pass_q;
	logic [1:0] gsel_q;
	logic [SUM_W+RECIP_W-1:0] prod_q;
	logic [SMP_W-1:0] fa_a_q, fa_b_q, sa_a_q;
	logic [SMP_W-1:0] avg;
	logic [SUM_W-1:0] kept_sum;
	logic [SMP_W-1:0] x1, x2, y1, y2;
	logic [SMP_W-1:0] dx, dy;
	logic [SMP_W:0] sx, sy;
	logic [SMP_W-1:0] rx_q, ry_q;
	logic ok_q;
	logic signed [PROD_W-1:0] px_q, py_q;
	logic [COORD_W-1:0] scx, scy;
	logic [COORD_W-1:0] held_x_q, held_y_q, start_x_q, start_y_q;
	logic pen_q, newp_q;
	result_t nxt;
	result_t result_q;
	logic result_valid_q;
	logic out_free;
	logic emit;
	logic is_event;

	function automatic logic [COORD_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-17:0] q;
		begin
			q = v[PROD_W-1:16];
			if (v[PROD_W-1]) begin
				sat16 = '0;
			end else if (|q[PROD_W-17:COORD_W]) begin
				sat16 = COORD_IDLE;
			end else begin
				sat16 = q[COORD_W-1:0];
			end
		end
	endfunction

	assign out_free = !result_valid_q || result_ready;
	assign is_event = (q_rdata.op == OP_PEN_UP) || (q_rdata.op == OP_ACK);
	assign q_pop = !q_empty && (state_q == ST_IDLE) && (!is_event || out_free);
	assign emit = (q_pop && is_event) || ((state_q == ST_SCALE) && out_free);
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_comb begin
		sorted = grp_q;
		for (int i = 0; i < SAMPLES_PER_AXIS - 1; i++) begin
			if (((i % 2) == int'(pass_q[0])) && (grp_q[i] > grp_q[i+1])) begin
				sorted[i] = grp_q[i+1];
				sorted[i+1] = grp_q[i];
			end
		end
	end

	always_comb begin
		kept_sum = '0;
		for (int i = DROP_EACH_END; i < SAMPLES_PER_AXIS - DROP_EACH_END; i++) begin
			kept_sum = kept_sum + SUM_W'(grp_q[i]);
		end
	end

	assign avg = prod_q[32 +: SMP_W];

	always_comb begin
		if (cfg.swap_axes) begin
			x1 = sa_a_q;
			x2 = avg;
			y1 = fa_a_q;
			y2 = fa_b_q;
		end else begin
			x1 = fa_a_q;
			x2 = fa_b_q;
			y1 = sa_a_q;
			y2 = avg;
		end
		dx = (x1 > x2) ? x1 - x2 : x2 - x1;
		dy = (y1 > y2) ? y1 - y2 : y2 - y1;
		sx = {1'b0, x1} + {1'b0, x2};
		sy = {1'b0, y1} + {1'b0, y2};
	end

	assign scx = sat16(px_q + PROD_W'(cfg.x_offset));
	assign scy = sat16(py_q + PROD_W'(cfg.y_offset));

	always_comb begin
		nxt.pos_x = held_x_q;
		nxt.pos_y = held_y_q;
		nxt.start_x = start_x_q;
		nxt.start_y = start_y_q;
		nxt.pressed = pen_q;
		nxt.new_press = newp_q;
		nxt.reading_valid = 1'b0;
		if (state_q == ST_SCALE) begin
			if (ok_q) begin
				nxt.pos_x = cfg.output_mode ? COORD_W'(rx_q) : scx;
				nxt.pos_y = cfg.output_mode ? COORD_W'(ry_q) : scy;
				nxt.reading_valid = 1'b1;
			end
			if (!pen_q) begin
				nxt.pressed = 1'b1;
				nxt.new_press = 1'b1;
				nxt.start_x = nxt.pos_x;
				nxt.start_y = nxt.pos_y;
			end
		end else if (q_rdata.op == OP_PEN_UP) begin
			if (pen_q) begin
				nxt.pressed = 1'b0;
			end else begin
				nxt.pos_x = COORD_IDLE;
				nxt.pos_y = COORD_IDLE;
				nxt.start_x = '0;
				nxt.start_y = '0;
			end
		end else begin
			nxt.new_press = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_pop && !is_event) begin
					grp_q[q_rdata.idx] <= q_rdata.sample;
					gsel_q <= q_rdata.grp;
					pass_q <= '0;
				end
			end
			ST_SORT: begin
				grp_q <= sorted;
				pass_q <= pass_q + IDX_W'(1);
			end
			ST_MEAN: begin
				prod_q <= kept_sum * RECIP;
			end
			ST_STORE: begin
				case (gsel_q)
					GRP_FIRST_A: fa_a_q <= avg;
					GRP_SECOND_A: sa_a_q <= avg;
					GRP_FIRST_B: fa_b_q <= avg;
					default: begin
						ok_q <= (dx < cfg.agree_lim) && (dy < cfg.agree_lim);
						rx_q <= sx[SMP_W:1];
						ry_q <= sy[SMP_W:1];
					end
				endcase
			end
			ST_CHECK: begin
				px_q <= PROD_W'(cfg.x_gain * $signed({1'b0, rx_q}));
				py_q <= PROD_W'(cfg.y_gain * $signed({1'b0, ry_q}));
			end
			default: begin
			end
		endcase
		if (emit) begin
			result_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_x_q <= '0;
			held_y_q <= '0;
			start_x_q <= '0;
			start_y_q <= '0;
			pen_q <= 1'b0;
			newp_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				held_x_q <= nxt.pos_x;
				held_y_q <= nxt.pos_y;
				start_x_q <= nxt.start_x;
				start_y_q <= nxt.start_y;
				pen_q <= nxt.pressed;
				newp_q <= nxt.new_press;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop && (q_rdata.op == OP_GROUP_END)) begin
						state_q <= ST_SORT;
					end
				end
				ST_SORT: begin
					if (pass_q == IDX_W'(SAMPLES_PER_AXIS - 1)) begin
						state_q <= ST_MEAN;
					end
				end
				ST_MEAN: state_q <= ST_STORE;
				ST_STORE: state_q <= (gsel_q == GRP_SECOND_B) ? ST_CHECK : ST_IDLE;
				ST_CHECK: state_q <= ST_SCALE;
				ST_SCALE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/touch_sample_filter_and_press_tracker.sv */
// Touch sample filter and press tracker: top level with configuration registers.
// The front end takes one transaction per cycle while the two-entry queue has room.
// In the back end a sample that does not close a group is only stored; a group-closing
// sample goes on through SAMPLES_PER_AXIS sort passes, mean and store, and a set-closing
// one through check and scale, which loads the result; pen-up and acknowledge load it
// when popped. A stalled result holds the back end. Reset loads defaults.
module touch_sample_filter_and_press_tracker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input tsf_pkg::item_t item,
	output logic result_valid,
	input logic result_ready,
	output tsf_pkg::result_t result,
	input logic cfg_we,
	input logic [tsf_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [tsf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tsf_pkg::*;

	cfg_t cfg_q;
	q_ctl_t q_ctl;
	q_sts_t q_sts;
	op_t q_wdata;
	op_t q_rdata;
	logic q_push;
	logic q_pop;

	assign q_ctl = '{push: q_push, pop: q_pop};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.output_mode <= 1'b0;
			cfg_q.swap_axes <= 1'b0;
			cfg_q.agree_lim <= AGREE_LIM_RST;
			cfg_q.x_gain <= '0;
			cfg_q.x_offset <= '0;
			cfg_q.y_gain <= '0;
			cfg_q.y_offset <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_OUTPUT_MODE: cfg_q.output_mode <= cfg_data[0];
				REG_SWAP_AXES: cfg_q.swap_axes <= cfg_data[0];
				REG_AGREE_LIM: cfg_q.agree_lim <= cfg_data[SMP_W-1:0];
				REG_X_GAIN: cfg_q.x_gain <= cfg_data;
				REG_X_OFFSET: cfg_q.x_offset <= cfg_data;
				REG_Y_GAIN: cfg_q.y_gain <= cfg_data;
				REG_Y_OFFSET: cfg_q.y_offset <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tsf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.q_sts(q_sts),
		.q_push(q_push),
		.q_wdata(q_wdata)
	);

	tsf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.q_ctl(q_ctl),
		.wdata(q_wdata),
		.rdata(q_rdata),
		.q_sts(q_sts)
	);

	tsf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_rdata(q_rdata),
		.q_empty(q_sts.empty),
		.q_pop(q_pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

endmodule

/* test/tb_top.sv */
// Self-checking testbench for touch_sample_filter_and_press_tracker: random bursts of
// samples, pen-up and acknowledge transactions checked against an in-bench predictor.
// Depends on tsf_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb_top;
	import tsf_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_REPORTS = 30;

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	touch_sample_filter_and_press_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	item_t pending_items[$];
	result_t touch_reports[$];

	// Predictor copy of the press tracker and its settings.
	logic [SMP_W-1:0] grp_buf [SAMPLES_PER_AXIS];
	int grp_fill = 0;
	logic [1:0] grp_phase = GRP_FIRST_A;
	logic [SMP_W-1:0] axis1_rd0 = '0, axis1_rd1 = '0, axis2_rd0 = '0;
	logic [COORD_W-1:0] cur_x = '0, cur_y = '0, origin_x = '0, origin_y = '0;
	logic pen_is_down = 1'b0, press_pending = 1'b0;
	logic mode_raw = 1'b0, axes_swapped = 1'b0;
	logic [SMP_W-1:0] agree_limit = AGREE_LIM_RST;
	logic signed [31:0] gain_x = '0, ofs_x = '0, gain_y = '0, ofs_y = '0;

	int report_errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	int sets_agreed = 0;
	int sets_rejected = 0;
	int settings_used = 1;
	int phase_items = 0;

	function automatic logic [SMP_W-1:0] trimmed_avg();
		logic [SMP_W-1:0] srt [SAMPLES_PER_AXIS];
		logic [SMP_W-1:0] t;
		int acc;
		int kept;
		srt = grp_buf;
		for (int i = 0; i + 1 < SAMPLES_PER_AXIS; i++)
			for (int j = i + 1; j < SAMPLES_PER_AXIS; j++)
				if (srt[i] > srt[j]) begin
					t = srt[i];
					srt[i] = srt[j];
					srt[j] = t;
				end
		acc = 0;
		kept = 0;
		for (int i = DROP_EACH_END; i + DROP_EACH_END < SAMPLES_PER_AXIS; i++) begin
			acc += int'(srt[i]);
			kept++;
		end
		return (kept > 0) ? SMP_W'(acc / kept) : '0;
	endfunction

	function automatic int spread(logic [SMP_W-1:0] a, logic [SMP_W-1:0] b);
		return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
	endfunction

	function automatic logic [COORD_W-1:0] to_screen(logic signed [31:0] gain,
			logic signed [31:0] ofs, logic [SMP_W:0] raw);
		longint g;
		longint o;
		longint r;
		longint v;
		g = longint'(gain);
		o = longint'(ofs);
		r = longint'(raw);
		v = g * r + o;
		if (v < 0)
			return '0;
		if ((v >>> 16) > 65535)
			return COORD_IDLE;
		return v[31:16];
	endfunction

	task automatic track_touch(input item_t it);
		result_t r;
		logic [SMP_W-1:0] avg, x1, x2, y1, y2;
		logic [SMP_W:0] rx, ry;
		logic agreed;
		logic emit;
		agreed = 1'b0;
		emit = 1'b1;
		case (it.kind)
			KIND_SAMPLE: begin
				grp_buf[grp_fill] = it.sample;
				if (grp_fill < SAMPLES_PER_AXIS - 1) begin
					grp_fill++;
					emit = 1'b0;
				end else begin
					grp_fill = 0;
					avg = trimmed_avg();
					case (grp_phase)
						GRP_FIRST_A: axis1_rd0 = avg;
						GRP_SECOND_A: axis2_rd0 = avg;
						GRP_FIRST_B: axis1_rd1 = avg;
						default: begin
							if (axes_swapped) begin
								x1 = axis2_rd0;
								x2 = avg;
								y1 = axis1_rd0;
								y2 = axis1_rd1;
							end else begin
								x1 = axis1_rd0;
								x2 = axis1_rd1;
								y1 = axis2_rd0;
								y2 = avg;
							end
							if (spread(x1, x2) < int'(agree_limit) &&
									spread(y1, y2) < int'(agree_limit)) begin
								rx = ({1'b0, x1} + {1'b0, x2}) >> 1;
								ry = ({1'b0, y1} + {1'b0, y2}) >> 1;
								if (mode_raw) begin
									cur_x = COORD_W'(rx);
									cur_y = COORD_W'(ry);
								end else begin
									cur_x = to_screen(gain_x, ofs_x, rx);
									cur_y = to_screen(gain_y, ofs_y, ry);
								end
								agreed = 1'b1;
								sets_agreed++;
							end else begin
								sets_rejected++;
							end
							if (!pen_is_down) begin
								pen_is_down = 1'b1;
								press_pending = 1'b1;
								origin_x = cur_x;
								origin_y = cur_y;
							end
						end
					endcase
					emit = (grp_phase == GRP_SECOND_B);
					grp_phase = grp_phase + 2'd1;
				end
			end
			KIND_PEN_UP: begin
				grp_fill = 0;
				grp_phase = GRP_FIRST_A;
				if (pen_is_down) begin
					pen_is_down = 1'b0;
				end else begin
					origin_x = '0;
					origin_y = '0;
					cur_x = COORD_IDLE;
					cur_y = COORD_IDLE;
				end
			end
			KIND_ACK: press_pending = 1'b0;
			default: emit = 1'b0;
		endcase
		if (emit) begin
			r.pos_x = cur_x;
			r.pos_y = cur_y;
			r.start_x = origin_x;
			r.start_y = origin_y;
			r.pressed = pen_is_down;
			r.new_press = press_pending;
			r.reading_valid = agreed;
			touch_reports.push_back(r);
		end
	endtask

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) begin
				track_touch(item);
				items_sent++;
			end
			if (!item_valid || item_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string what, input logic [COORD_W-1:0] want_v,
			input logic [COORD_W-1:0] got_v);
		if (got_v !== want_v) begin
			report_errors++;
			if (report_errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
		end
	endtask

	// Receiver: ready follows a stall mode that is itself changed at random.
	result_t head;
	int stall_mode = 0;
	int stall_left = 0;
	int stall_tick = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (touch_reports.size() == 0) begin
					report_errors++;
					if (report_errors <= MAX_REPORTS)
						$display("%0t: unexpected result, expected none, got %h", $time, result);
				end else begin
					head = touch_reports.pop_front();
					results_seen++;
					check_field("pos_x", head.pos_x, result.pos_x);
					check_field("pos_y", head.pos_y, result.pos_y);
					check_field("start_x", head.start_x, result.start_x);
					check_field("start_y", head.start_y, result.start_y);
					check_field("pressed", COORD_W'(head.pressed), COORD_W'(result.pressed));
					check_field("new_press", COORD_W'(head.new_press),
						COORD_W'(result.new_press));
					check_field("reading_valid", COORD_W'(head.reading_valid),
						COORD_W'(result.reading_valid));
				end
			end
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(20, 200);
			end else begin
				stall_left--;
			end
			stall_tick++;
			case (stall_mode)
				0: result_ready <= 1'b1;
				1: result_ready <= 1'($urandom_range(0, 1));
				2: result_ready <= (stall_tick % 4 == 0);
				default: result_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_OUTPUT_MODE: mode_raw = val[0];
			REG_SWAP_AXES: axes_swapped = val[0];
			REG_AGREE_LIM: agree_limit = val[SMP_W-1:0];
			REG_X_GAIN: gain_x = val;
			REG_X_OFFSET: ofs_x = val;
			REG_Y_GAIN: gain_y = val;
			REG_Y_OFFSET: ofs_y = val;
			default: ;
		endcase
	endtask

	task automatic set_registers(input logic mode, input logic swap, input logic [11:0] err,
			input logic [31:0] xg, input logic [31:0] xo, input logic [31:0] yg,
			input logic [31:0] yo);
		write_reg(REG_OUTPUT_MODE, 32'(mode));
		write_reg(REG_SWAP_AXES, 32'(swap));
		write_reg(REG_AGREE_LIM, 32'(err));
		write_reg(REG_X_GAIN, xg);
		write_reg(REG_X_OFFSET, xo);
		write_reg(REG_Y_GAIN, yg);
		write_reg(REG_Y_OFFSET, yo);
		settings_used++;
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || item_valid || touch_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_q16(logic [31:0] span);
		case ($urandom_range(0, 2))
			0: return $urandom;
			1: return $urandom_range(0, span);
			default: return -$urandom_range(0, span);
		endcase
	endfunction

	function automatic logic [SMP_W-1:0] near(int center, int noise);
		int v;
		if ($urandom_range(0, 9) == 0)
			v = $urandom_range(0, 4095);
		else
			v = center + int'($urandom_range(0, 2 * noise)) - noise;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v[SMP_W-1:0];
	endfunction

	task automatic queue_item(input logic [1:0] kind, input logic [SMP_W-1:0] smp);
		item_t it;
		it.kind = kind;
		it.sample = smp;
		pending_items.push_back(it);
		if (kind != KIND_UNUSED)
			phase_items++;
	endtask

	task automatic queue_touch();
		int cx, cy, cxb, cyb, noise, sets, c;
		cx = $urandom_range(0, 4095);
		cy = $urandom_range(0, 4095);
		sets = $urandom_range(1, 4);
		for (int s = 0; s < sets; s++) begin
			case ($urandom_range(0, 4))
				0: noise = 0;
				1: noise = 3;
				2: noise = 15;
				3: noise = 60;
				default: noise = 400;
			endcase
			cxb = cx + int'($urandom_range(0, 2 * noise)) - noise;
			cyb = cy + int'($urandom_range(0, 2 * noise)) - noise;
			for (int g = 0; g < 4; g++) begin
				case (g)
					0: c = cx;
					1: c = cy;
					2: c = cxb;
					default: c = cyb;
				endcase
				for (int k = 0; k < SAMPLES_PER_AXIS; k++) begin
					if ($urandom_range(0, 39) == 0)
						queue_item(KIND_ACK, SMP_W'($urandom_range(0, 4095)));
					if ($urandom_range(0, 59) == 0)
						queue_item(KIND_UNUSED, SMP_W'($urandom_range(0, 4095)));
					queue_item(KIND_SAMPLE, near(c, noise));
				end
			end
			if ($urandom_range(0, 3) == 0)
				queue_item(KIND_ACK, SMP_W'($urandom_range(0, 4095)));
		end
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 4 * SAMPLES_PER_AXIS - 1))
				queue_item(KIND_SAMPLE, near(cx, 20));
		queue_item(KIND_PEN_UP, SMP_W'($urandom_range(0, 4095)));
		if ($urandom_range(0, 2) == 0)
			queue_item(KIND_PEN_UP, SMP_W'($urandom_range(0, 4095)));
	endtask

	task automatic queue_noise();
		logic [1:0] k;
		repeat ($urandom_range(3, 20)) begin
			k = ($urandom_range(0, 1) == 0) ? KIND_SAMPLE : 2'($urandom_range(0, 3));
			queue_item(k, SMP_W'($urandom_range(0, 4095)));
		end
	endtask

	task automatic run_phase(input int budget);
		phase_items = 0;
		while (phase_items < budget) begin
			if ($urandom_range(0, 6) == 0)
				queue_noise();
			else
				queue_touch();
		end
		wait_idle();
	endtask

	initial begin
		logic [11:0] err;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: idle pen-up, lone acknowledge, ignored kind, one set of
		// groups built from the sample extremes, then pen-up while pressed and idle.
		queue_item(KIND_PEN_UP, 12'hFFF);
		queue_item(KIND_ACK, 12'h000);
		queue_item(KIND_UNUSED, 12'hFFF);
		for (int g = 0; g < 4; g++) begin
			queue_item(KIND_SAMPLE, 12'hFFF);
			queue_item(KIND_SAMPLE, 12'h000);
			queue_item(KIND_SAMPLE, 12'hAAA);
			queue_item(KIND_SAMPLE, 12'h555);
			queue_item(KIND_SAMPLE, 12'h800);
		end
		queue_item(KIND_PEN_UP, 12'h555);
		queue_item(KIND_PEN_UP, 12'hAAA);
		wait_idle();

		set_registers(1'b1, 1'b0, 12'd4095, '0, '0, '0, '0);
		run_phase(250);
		set_registers(1'b0, 1'b1, 12'd50, 32'h0010_0000, 32'h0000_0000, 32'h000F_0000,
			-32'sh0064_0000);
		run_phase(300);
		set_registers(1'b0, 1'b0, 12'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF);
		run_phase(200);
		for (int p = 0; p < 4; p++) begin
			err = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(1, 4095)) :
				12'($urandom_range(1, 120));
			set_registers(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), err,
				rand_q16(32'h0020_0000), rand_q16(32'h07D0_0000),
				rand_q16(32'h0020_0000), rand_q16(32'h07D0_0000));
			run_phase(240);
		end

		$display("Covered %0d transactions under %0d register settings; %0d results checked.",
			items_sent, settings_used, results_seen);
		$display("Completed sets: %0d readings agreed, %0d rejected.", sets_agreed, sets_rejected);
		if (report_errors == 0 && touch_reports.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
